/* design/assert_macros.svh */
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PP_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PP_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/pospid_pkg.sv */
package pospid_pkg;

	// Register map (index = paddr[4:2])
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_POS_TOL     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 3'd7;

	// Reset values
	localparam logic [30:0] INTEG_LIMIT_RST = 31'd262144000;
	localparam logic [14:0] DRIVE_LIMIT_RST = 15'd6000;
	localparam logic [15:0] POS_TOL_RST     = 16'd655;
	localparam logic [15:0] SETTLE_RST      = 16'd10;
	localparam logic [15:0] TIMEOUT_RST     = 16'd100;

	// 25-bit signed gain times 33-bit signed error, and the widened PID sum
	localparam int PROD_W = 58;
	localparam int SUM_W  = 60;

	typedef struct packed {
		logic [23:0] gain_p;
		logic [23:0] gain_i;
		logic [23:0] gain_d;
		logic [30:0] integ_limit;
		logic [14:0] drive_limit;
		logic [15:0] position_tolerance;
		logic [15:0] settle_ticks;
		logic [15:0] timeout_ticks;
	} pospid_cfg_t;

	// One tick handed from the tracking stage to the control-law stage
	typedef struct packed {
		logic                     run;
		logic                     settled;
		logic                     fault;
		logic signed [PROD_W-1:0] p_term;
		logic signed [PROD_W-1:0] i_term;
		logic signed [PROD_W-1:0] d_term;
	} pospid_tick_t;

endpackage

/* design/pospid_regs.sv */
module pospid_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pospid_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output pospid_pkg::pospid_cfg_t      cfg
);
	import pospid_pkg::*;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	pospid_cfg_t          cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p             <= '0;
			cfg_q.gain_i             <= '0;
			cfg_q.gain_d             <= '0;
			cfg_q.integ_limit        <= INTEG_LIMIT_RST;
			cfg_q.drive_limit        <= DRIVE_LIMIT_RST;
			cfg_q.position_tolerance <= POS_TOL_RST;
			cfg_q.settle_ticks       <= SETTLE_RST;
			cfg_q.timeout_ticks      <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:      cfg_q.gain_p             <= pwdata[23:0];
				REG_GAIN_I:      cfg_q.gain_i             <= pwdata[23:0];
				REG_GAIN_D:      cfg_q.gain_d             <= pwdata[23:0];
				REG_INTEG_LIMIT: cfg_q.integ_limit        <= pwdata[30:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit        <= pwdata[14:0];
				REG_POS_TOL:     cfg_q.position_tolerance <= pwdata[15:0];
				REG_SETTLE:      cfg_q.settle_ticks       <= pwdata[15:0];
				REG_TIMEOUT:     cfg_q.timeout_ticks      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:      prdata = {8'd0, cfg_q.gain_p};
			REG_GAIN_I:      prdata = {8'd0, cfg_q.gain_i};
			REG_GAIN_D:      prdata = {8'd0, cfg_q.gain_d};
			REG_INTEG_LIMIT: prdata = {1'b0, cfg_q.integ_limit};
			REG_DRIVE_LIMIT: prdata = {17'd0, cfg_q.drive_limit};
			REG_POS_TOL:     prdata = {16'd0, cfg_q.position_tolerance};
			REG_SETTLE:      prdata = {16'd0, cfg_q.settle_ticks};
			REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ticks};
			default:         prdata = '0;
		endcase
	end

endmodule

/* design/pospid_track.sv */
module pospid_track #(
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pospid_pkg::pospid_cfg_t   cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        target_position,
	input  logic                      sample_valid,
	input  logic signed [31:0]        sample_position,
	input  logic signed [31:0]        sample_speed,
	input  logic                      law_ready,
	output logic                      tick_valid,
	output pospid_pkg::pospid_tick_t  tick
);
	import pospid_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Input register
	logic               v_s1;
	logic signed [31:0] tgt_s1;
	logic               sv_s1;
	logic signed [31:0] pos_s1;
	logic signed [31:0] spd_s1;

	// Tick state
	logic signed [31:0]      held_pos_q;
	logic signed [31:0]      held_spd_q;
	logic signed [31:0]      setpoint_q;
	logic [COUNT_WIDTH-1:0]  missed_q;
	logic [COUNT_WIDTH-1:0]  settle_q;
	logic                    settled_q;
	logic                    fault_q;

	logic               v_s2;
	pospid_tick_t       tick_s2;

	logic                   s2_free;
	logic                   adv1;
	logic signed [31:0]     new_pos;
	logic signed [31:0]     new_spd;
	logic [COUNT_WIDTH-1:0] missed_inc;
	logic                   timeout_hit;
	logic [COUNT_WIDTH-1:0] missed_nx;
	logic signed [33:0]     diff;
	logic signed [33:0]     tol_x;
	logic                   in_win;
	logic [COUNT_WIDTH-1:0] settle_inc;
	logic                   settle_hit;
	logic [COUNT_WIDTH-1:0] settle_nx;
	logic                   settled_nx;
	logic signed [32:0]     err;
	logic signed [PROD_W-1:0] p_prod;
	logic signed [PROD_W-1:0] i_prod;
	logic signed [PROD_W-1:0] d_prod;

	assign s2_free    = !v_s2 || law_ready;
	assign adv1       = v_s1 && s2_free;
	assign in_ready   = !v_s1 || s2_free;
	assign tick_valid = v_s2;
	assign tick       = tick_s2;

	// Watchdog: a fresh sample replaces the held values and clears the miss count
	assign new_pos     = sv_s1 ? pos_s1 : held_pos_q;
	assign new_spd     = sv_s1 ? spd_s1 : held_spd_q;
	assign missed_inc  = (missed_q != CNT_MAX) ? missed_q + 1'b1 : missed_q;
	assign timeout_hit = !sv_s1 && (CMP_W'(missed_inc) >= CMP_W'(cfg.timeout_ticks));
	assign missed_nx   = (sv_s1 || timeout_hit) ? '0 : missed_inc;

	// Settle window checked against the setpoint from the previous tick
	assign diff       = {{2{setpoint_q[31]}}, setpoint_q} - {{2{new_pos[31]}}, new_pos};
	assign tol_x      = $signed({18'd0, cfg.position_tolerance});
	assign in_win     = (diff < tol_x) && (diff > -tol_x);
	assign settle_inc = in_win ? ((settle_q != CNT_MAX) ? settle_q + 1'b1 : settle_q) : '0;
	assign settle_hit = CMP_W'(settle_inc) > CMP_W'(cfg.settle_ticks);
	assign settle_nx  = settle_hit ? COUNT_WIDTH'(cfg.settle_ticks) : settle_inc;
	assign settled_nx = (tgt_s1 != setpoint_q) ? 1'b0 : (settled_q | settle_hit);

	// Error against the new setpoint and the three gain products
	assign err    = {tgt_s1[31], tgt_s1} - {new_pos[31], new_pos};
	assign p_prod = $signed({1'b0, cfg.gain_p}) * err;
	assign i_prod = $signed({1'b0, cfg.gain_i}) * err;
	assign d_prod = $signed({1'b0, cfg.gain_d}) * new_spd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (s2_free)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tgt_s1 <= target_position;
			sv_s1  <= sample_valid;
			pos_s1 <= sample_position;
			spd_s1 <= sample_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_pos_q <= '0;
			held_spd_q <= '0;
			setpoint_q <= '0;
			missed_q   <= '0;
			settle_q   <= '0;
			settled_q  <= 1'b0;
			fault_q    <= 1'b0;
		end else if (adv1 && !fault_q) begin
			held_pos_q <= new_pos;
			held_spd_q <= new_spd;
			setpoint_q <= tgt_s1;
			missed_q   <= missed_nx;
			settle_q   <= settle_nx;
			settled_q  <= settled_nx;
			fault_q    <= timeout_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tick_s2.run     <= !fault_q && !timeout_hit;
			tick_s2.settled <= fault_q ? settled_q : settled_nx;
			tick_s2.fault   <= fault_q || timeout_hit;
			tick_s2.p_term  <= p_prod >>> FRAC_BITS;
			tick_s2.i_term  <= i_prod >>> FRAC_BITS;
			tick_s2.d_term  <= d_prod >>> FRAC_BITS;
		end
	end

endmodule

/* design/pospid_law.sv */
module pospid_law #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pospid_pkg::pospid_cfg_t  cfg,
	input  logic                     tick_valid,
	input  pospid_pkg::pospid_tick_t tick,
	output logic                     law_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [15:0]       drive,
	output logic                     at_position,
	output logic                     link_fault
);
	import pospid_pkg::*;

	logic                    adv2;
	logic                    out_valid_q;
	logic signed [31:0]      integ_q;
	logic signed [SUM_W-1:0] integ_sum;
	logic signed [SUM_W-1:0] lim;
	logic signed [SUM_W-1:0] integ_clamp;
	logic signed [31:0]      integ_nx;
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        mag_full;
	logic [SUM_W-1:0]        mag;
	logic [14:0]             mag_sat;
	logic signed [15:0]      drive_nx;
	logic signed [15:0]      drive_q;
	logic                    at_pos_q;
	logic                    fault_q;

	assign law_ready   = !out_valid_q || out_ready;
	assign adv2        = tick_valid && law_ready;
	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign at_position = at_pos_q;
	assign link_fault  = fault_q;

	// Integrate, then clamp to the symmetric limit
	assign integ_sum   = SUM_W'(integ_q) + SUM_W'(tick.i_term);
	assign lim         = $signed({{(SUM_W-31){1'b0}}, cfg.integ_limit});
	assign integ_clamp = (integ_sum > lim) ? lim : ((integ_sum < -lim) ? -lim : integ_sum);
	assign integ_nx    = integ_clamp[31:0];

	// Sum the terms, drop the fraction toward zero, saturate
	assign sum      = SUM_W'(tick.p_term) + SUM_W'(integ_nx) - SUM_W'(tick.d_term);
	assign mag_full = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
	assign mag      = mag_full >> FRAC_BITS;
	assign mag_sat  = (mag > SUM_W'(cfg.drive_limit)) ? cfg.drive_limit : mag[14:0];
	assign drive_nx = !tick.run ? 16'sd0 :
		(sum[SUM_W-1] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integ_q     <= '0;
		end else begin
			if (law_ready)
				out_valid_q <= tick_valid;
			if (adv2 && tick.run)
				integ_q <= integ_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			drive_q  <= drive_nx;
			at_pos_q <= tick.settled;
			fault_q  <= tick.fault;
		end
	end

endmodule

/* design/position_pid_with_settle_and_watchdog_core.sv */
// Throughput: one beat per cycle unless m_axis_tready is held low and stalls the
// result beat; the integrator closes its loop inside the law stage.
// Stages: input register, tracking/product register, result register.
// Reset: arst_n clears all tick state and valids at once and loads register defaults;
// no clearing pass follows, so the first beat may enter right after reset is released.
module position_pid_with_settle_and_watchdog_core #(
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pospid_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// tick input
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] target_position, [63:32] sample_position, [95:64] sample_speed
	input  logic [95:0]                   s_axis_tdata,
	// [0] sample_valid
	input  logic                          s_axis_tuser,
	// drive result
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] drive, [16] at_position, [17] link_fault, [23:18] zero
	output logic [23:0]                   m_axis_tdata
);
	import pospid_pkg::*;

	pospid_cfg_t        cfg;
	pospid_tick_t       tick;
	logic               tick_valid;
	logic               law_ready;
	logic signed [15:0] drive;
	logic               at_position;
	logic               link_fault;

	// Register file: gains, limits, settle and watchdog thresholds.
	pospid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Tracking stage: hold or replace the sample, run the watchdog and the
	// settle counter, swap in the new setpoint, and form the three products.
	// Once the watchdog trips, freeze the held sample, counters and setpoint, and mark every later beat faulted.
	pospid_track #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.target_position (s_axis_tdata[31:0]),
		.sample_valid    (s_axis_tuser),
		.sample_position (s_axis_tdata[63:32]),
		.sample_speed    (s_axis_tdata[95:64]),
		.law_ready       (law_ready),
		.tick_valid      (tick_valid),
		.tick            (tick)
	);

	// Control-law stage: advance the clamped integrator, sum the terms and
	// saturate the drive. Drop the drive to zero on a faulted beat.
	pospid_law #(
		.FRAC_BITS (FRAC_BITS)
	) u_law (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.tick_valid  (tick_valid),
		.tick        (tick),
		.law_ready   (law_ready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.drive       (drive),
		.at_position (at_position),
		.link_fault  (link_fault)
	);

	assign m_axis_tdata = {6'd0, link_fault, at_position, drive};

endmodule

/* design/pospid_checker.sv */
`include "assert_macros.svh"

module pospid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	logic beat;
	logic fault_seen_q;

	assign beat = m_axis_tvalid && m_axis_tready;

	// Remember that a faulted beat has left the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fault_seen_q <= 1'b0;
		else if (beat && m_axis_tdata[17])
			fault_seen_q <= 1'b1;
	end

	`PP_ASSERT_NOW(a_fault_zero_drive, clk, arst_n, m_axis_tvalid && m_axis_tdata[17], m_axis_tdata[15:0] == 16'd0, "faulted beat carries nonzero drive")
	`PP_ASSERT_NOW(a_fault_sticky, clk, arst_n, m_axis_tvalid && fault_seen_q, m_axis_tdata[17], "link fault cleared without reset")
	`PP_ASSERT_NOW(a_drive_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000, "drive outside symmetric range")
	`PP_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[23:18] == 6'd0, "result padding not zero")
	`PP_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

endmodule

bind position_pid_with_settle_and_watchdog_core pospid_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
